### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the projection RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk outside reset.
`define AST_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define AST_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### rtl/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared constants and helpers of the point projection pipeline.
// ----------------------------------------------------------------------------
package ppts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int COEF_NUM      = 32;
    localparam int IDX_W         = 5;
    localparam int VP_W          = 16;
    localparam int STATUS_W      = 3;
    localparam int DIV_STEP      = 4;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 72;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_W_SMALL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEPTH     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PROJ = 1'b1;

    localparam logic CFG_VP_WIDTH  = 1'b0;
    localparam logic CFG_VP_HEIGHT = 1'b1;

    // True when a 64-bit value lies in the signed 32-bit range.
    function automatic logic fits32(input logic [63:0] v);
        return (v[63:31] == {33{v[31]}});
    endfunction

endpackage

### rtl/ppts_div.sv
// ----------------------------------------------------------------------------
// ppts_div
// Pipelined unsigned restoring divider, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module ppts_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int STEP  = ppts_pkg::DIV_STEP
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    localparam int NS = (NUM_W + STEP - 1) / STEP;
    localparam int PW = NS * STEP;

    logic [PW-1:0]    num_reg [NS];
    logic [PW-1:0]    quo_reg [NS];
    logic [DEN_W-1:0] rem_reg [NS];
    logic [DEN_W-1:0] den_reg [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [PW-1:0]    n_in;
            logic [PW-1:0]    q_in;
            logic [DEN_W-1:0] r_in;
            logic [DEN_W-1:0] d_in;
            logic [PW-1:0]    n_next;
            logic [PW-1:0]    q_next;
            logic [DEN_W-1:0] r_next;

            if (k == 0) begin : g_first
                assign n_in = PW'(num);
                assign q_in = '0;
                assign r_in = '0;
                assign d_in = den;
            end else begin : g_rest
                assign n_in = num_reg[k-1];
                assign q_in = quo_reg[k-1];
                assign r_in = rem_reg[k-1];
                assign d_in = den_reg[k-1];
            end

            always_comb begin : p_steps
                logic [DEN_W:0] t;
                n_next = n_in;
                q_next = q_in;
                r_next = r_in;
                for (int j = 0; j < STEP; j++) begin
                    t      = {r_next, n_next[PW-1]};
                    n_next = {n_next[PW-2:0], 1'b0};
                    if (t >= {1'b0, d_in}) begin
                        r_next = DEN_W'(t - {1'b0, d_in});
                        q_next = {q_next[PW-2:0], 1'b1};
                    end else begin
                        r_next = t[DEN_W-1:0];
                        q_next = {q_next[PW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[k] <= n_next;
                    quo_reg[k] <= q_next;
                    rem_reg[k] <= r_next;
                    den_reg[k] <= d_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NS-1][NUM_W-1:0];

endmodule

### rtl/point_projection_to_screen_core.sv
// ----------------------------------------------------------------------------
// point_projection_to_screen_core
// Model-view and projection transform, perspective divide, depth reject and
// viewport mapping of Q16.16 points, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  s_      | in        | coefficient loads and points to project
//  m_      | out       | status and screen x/y, one per projected point
//  cfg_    | in        | viewport width (index 0) and height (index 1)
//
// One point enters per cycle while the pipeline is not held. The divider
// resolves four quotient bits per stage. A coefficient load is taken only
// once no point is in flight. The whole pipeline holds while the output
// register is full and not taken. Reset clears the valid bits, the loaded
// mask and the viewport.
module point_projection_to_screen_core #(
    parameter int FRAC_BITS = ppts_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: coef_index, coef_value, world_x, world_y, world_z, zero pad
    input  logic [ppts_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: status, screen_x, screen_y, zero pad
    output logic [ppts_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [ppts_pkg::VP_W-1:0]       cfg_wdata
);

    localparam int DW    = 32 + FRAC_BITS;
    localparam int ND    = (DW + ppts_pkg::DIV_STEP - 1) / ppts_pkg::DIV_STEP;
    localparam int NXW   = 36;
    localparam int PXW   = NXW + ppts_pkg::VP_W + 1;
    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int WMIN  = (ONE_I + 9999) / 10000;
    localparam logic [DW-1:0]         ONE_Q = DW'(ONE_I);
    localparam logic [DW-1:0]         NX_LIM = DW'(64'd1 << 33);
    localparam logic signed [NXW-1:0] ONE_N = NXW'(ONE_I);

    typedef logic [ppts_pkg::STATUS_W-1:0] status_t;
    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] prod_t;

    // Configuration and coefficient store.
    logic [ppts_pkg::VP_W-1:0] vw_reg, vh_reg;
    word_t                     coef_reg [ppts_pkg::COEF_NUM];
    logic [ppts_pkg::COEF_NUM-1:0] loaded_reg;

    // Pipeline registers.
    logic    a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg, f_vld_reg;
    logic    g_vld_reg, h_vld_reg, m_vld_reg;
    logic    a_nr_reg, b_nr_reg;
    status_t c_st_reg, d_st_reg, e_st_reg, f_st_reg, g_st_reg, h_st_reg, m_st_reg;
    word_t   a_pt_reg [3];
    prod_t   b_prod_reg [4][3];
    word_t   c_eye_reg [4];
    prod_t   d_prod_reg [4][4];
    word_t   e_clip_reg [4];
    logic [DW-1:0] f_num_reg [3];
    logic [31:0]   f_den_reg;
    logic [2:0]    f_neg_reg;
    logic          dl_vld_reg [ND];
    status_t       dl_st_reg [ND];
    logic [2:0]    dl_neg_reg [ND];
    logic signed [NXW-1:0] g_tx_reg, g_ty_reg;
    logic signed [PXW-1:0] h_px_reg, h_py_reg;
    word_t   m_sx_reg, m_sy_reg;

    logic en, busy, in_acc, dl_busy;
    logic [DW-1:0] quo [3];

    assign en = !m_vld_reg || m_tready;

    always_comb begin
        dl_busy = 1'b0;
        for (int k = 0; k < ND; k++) begin
            dl_busy = dl_busy | dl_vld_reg[k];
        end
    end

    assign busy = a_vld_reg | b_vld_reg | c_vld_reg | d_vld_reg | e_vld_reg |
                  f_vld_reg | dl_busy | g_vld_reg | h_vld_reg;
    assign s_tready = en && (s_tuser == ppts_pkg::ACT_PROJ || !busy);
    assign in_acc   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vw_reg <= '0;
            vh_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                ppts_pkg::CFG_VP_WIDTH:  vw_reg <= cfg_wdata;
                ppts_pkg::CFG_VP_HEIGHT: vh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coefficient loads; the store itself needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
        end else if (in_acc && s_tuser == ppts_pkg::ACT_LOAD) begin
            loaded_reg[s_tdata[4:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_tuser == ppts_pkg::ACT_LOAD) begin
            coef_reg[s_tdata[4:0]] <= s_tdata[36:5];
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            for (int k = 0; k < ND; k++) begin
                dl_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            a_vld_reg <= in_acc && s_tuser == ppts_pkg::ACT_PROJ;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            dl_vld_reg[0] <= f_vld_reg;
            for (int k = 1; k < ND; k++) begin
                dl_vld_reg[k] <= dl_vld_reg[k-1];
            end
            g_vld_reg <= dl_vld_reg[ND-1];
            h_vld_reg <= g_vld_reg;
            m_vld_reg <= h_vld_reg;
        end
    end

    // Model-view sums, projection sums, divider setup.
    word_t   c_eye_next [4];
    status_t c_st_next;
    word_t   e_clip_next [4];
    status_t e_st_next;
    logic [DW-1:0] f_num_next [3];
    logic [31:0]   f_den_next;
    logic [2:0]    f_neg_next;
    status_t       f_st_next;

    always_comb begin : p_eye
        prod_t acc;
        logic  ovf;
        ovf = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = 64'(coef_reg[12 + r]);
            for (int c = 0; c < 3; c++) begin
                acc = acc + (b_prod_reg[r][c] >>> FRAC_BITS);
            end
            c_eye_next[r] = acc[31:0];
            ovf = ovf | !ppts_pkg::fits32(acc);
        end
        if (b_nr_reg) begin
            c_st_next = ppts_pkg::ST_NOT_READY;
        end else if (ovf) begin
            c_st_next = ppts_pkg::ST_OVERFLOW;
        end else begin
            c_st_next = ppts_pkg::ST_OK;
        end
    end

    always_comb begin : p_clip
        prod_t acc;
        logic  ovf;
        ovf = 1'b0;
        for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int c = 0; c < 4; c++) begin
                acc = acc + (d_prod_reg[r][c] >>> FRAC_BITS);
            end
            e_clip_next[r] = acc[31:0];
            ovf = ovf | !ppts_pkg::fits32(acc);
        end
        e_st_next = (d_st_reg == ppts_pkg::ST_OK && ovf) ? ppts_pkg::ST_OVERFLOW : d_st_reg;
    end

    always_comb begin : p_divsetup
        logic [31:0] absv;
        for (int i = 0; i < 3; i++) begin
            absv = e_clip_reg[i][31] ? (~e_clip_reg[i] + 32'd1) : e_clip_reg[i];
            f_num_next[i] = DW'(absv) << FRAC_BITS;
            f_neg_next[i] = e_clip_reg[i][31] ^ e_clip_reg[3][31];
        end
        f_den_next = e_clip_reg[3][31] ? (~e_clip_reg[3] + 32'd1) : e_clip_reg[3];
        if (e_st_reg == ppts_pkg::ST_OK && f_den_next < 32'(WMIN)) begin
            f_st_next = ppts_pkg::ST_W_SMALL;
        end else begin
            f_st_next = e_st_reg;
        end
    end

    // Depth reject, range check and viewport offset after the divide.
    status_t g_st_next;
    logic signed [NXW-1:0] g_tx_next, g_ty_next;

    always_comb begin : p_ndc
        logic signed [NXW-1:0] nx, ny;
        nx = dl_neg_reg[ND-1][0] ? -$signed(NXW'(quo[0])) : $signed(NXW'(quo[0]));
        ny = dl_neg_reg[ND-1][1] ? -$signed(NXW'(quo[1])) : $signed(NXW'(quo[1]));
        g_tx_next = nx + ONE_N;
        g_ty_next = ONE_N - ny;
        g_st_next = dl_st_reg[ND-1];
        if (dl_st_reg[ND-1] == ppts_pkg::ST_OK) begin
            if (quo[2] > ONE_Q) begin
                g_st_next = ppts_pkg::ST_DEPTH;
            end else if (quo[0] > NX_LIM || quo[1] > NX_LIM) begin
                g_st_next = ppts_pkg::ST_OVERFLOW;
            end
        end
    end

    // Final halving and range check.
    status_t m_st_next;
    word_t   m_sx_next, m_sy_next;

    always_comb begin : p_screen
        logic signed [PXW-1:0] sxw, syw;
        logic fit;
        sxw = h_px_reg >>> 1;
        syw = h_py_reg >>> 1;
        fit = (sxw[PXW-1:31] == {(PXW-31){sxw[31]}}) &&
              (syw[PXW-1:31] == {(PXW-31){syw[31]}});
        if (h_st_reg == ppts_pkg::ST_OK && !fit) begin
            m_st_next = ppts_pkg::ST_OVERFLOW;
        end else begin
            m_st_next = h_st_reg;
        end
        m_sx_next = (m_st_next == ppts_pkg::ST_OK) ? sxw[31:0] : '0;
        m_sy_next = (m_st_next == ppts_pkg::ST_OK) ? syw[31:0] : '0;
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_nr_reg    <= (loaded_reg != '1) || vw_reg == '0 || vh_reg == '0;
            a_pt_reg[0] <= s_tdata[68:37];
            a_pt_reg[1] <= s_tdata[100:69];
            a_pt_reg[2] <= s_tdata[132:101];
            b_nr_reg    <= a_nr_reg;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    b_prod_reg[r][c] <= coef_reg[c*4 + r] * a_pt_reg[c];
                end
            end
            c_st_reg  <= c_st_next;
            c_eye_reg <= c_eye_next;
            d_st_reg  <= c_st_reg;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    d_prod_reg[r][c] <= coef_reg[16 + c*4 + r] * c_eye_reg[c];
                end
            end
            e_st_reg   <= e_st_next;
            e_clip_reg <= e_clip_next;
            f_st_reg   <= f_st_next;
            f_num_reg  <= f_num_next;
            f_den_reg  <= f_den_next;
            f_neg_reg  <= f_neg_next;
            dl_st_reg[0]  <= f_st_reg;
            dl_neg_reg[0] <= f_neg_reg;
            for (int k = 1; k < ND; k++) begin
                dl_st_reg[k]  <= dl_st_reg[k-1];
                dl_neg_reg[k] <= dl_neg_reg[k-1];
            end
            g_st_reg <= g_st_next;
            g_tx_reg <= g_tx_next;
            g_ty_reg <= g_ty_next;
            h_st_reg <= g_st_reg;
            h_px_reg <= g_tx_reg * $signed({1'b0, vw_reg});
            h_py_reg <= g_ty_reg * $signed({1'b0, vh_reg});
            m_st_reg <= m_st_next;
            m_sx_reg <= m_sx_next;
            m_sy_reg <= m_sy_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < 3; i++) begin : g_div
            ppts_div #(
                .NUM_W (DW),
                .DEN_W (32),
                .STEP  (ppts_pkg::DIV_STEP)
            ) u_div (
                .aclk (aclk),
                .en   (en),
                .num  (f_num_reg[i]),
                .den  (f_den_reg),
                .quo  (quo[i])
            );
        end
    endgenerate

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'd0, m_sy_reg, m_sx_reg, m_st_reg};

`include "assert_macros.svh"

    `AST_RST(a_load_idle, (s_tvalid && s_tready && s_tuser == ppts_pkg::ACT_LOAD) |-> !busy, "coefficient load taken while a point is in flight")
    `AST_RST(a_zero_on_err, (m_tvalid && m_tdata[2:0] != ppts_pkg::ST_OK) |-> (m_tdata[66:3] == '0), "nonzero screen value with an error status")
    `AST_ALWAYS(a_reset_clear, !aresetn |=> !m_tvalid, "result valid right after reset")
    `AST_RST(a_stall_hold, (m_tvalid && !m_tready) |=> $stable(h_vld_reg), "pipeline moved during an output stall")

endmodule
